### rtl/core/bounded_linked_list_engine_top_macros.svh
// Assertion macros for the port-level checker.
// No dependencies.
`ifndef BOUNDED_LINKED_LIST_ENGINE_TOP_MACROS_SVH
`define BOUNDED_LINKED_LIST_ENGINE_TOP_MACROS_SVH
// implication checked on every edge outside reset
`define BLL_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define BLL_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

### rtl/core/blle_pkg.sv
// Package for the linked list engine: codes, widths, command/status structs.
// No dependencies.
`default_nettype none
package blle_pkg;
  localparam int unsigned CapacityDef = 32;
  localparam int unsigned ActW = 4;
  localparam int unsigned ValW = 32;
  localparam int unsigned PosW = 8;
  localparam int unsigned StW  = 3;
  localparam int unsigned OPosW = 7;

  localparam logic [ActW-1:0] ActInsBegin = 4'd0;
  localparam logic [ActW-1:0] ActInsEnd   = 4'd1;
  localparam logic [ActW-1:0] ActInsPos   = 4'd2;
  localparam logic [ActW-1:0] ActDelBegin = 4'd3;
  localparam logic [ActW-1:0] ActDelEnd   = 4'd4;
  localparam logic [ActW-1:0] ActDelPos   = 4'd5;
  localparam logic [ActW-1:0] ActSearch   = 4'd6;
  localparam logic [ActW-1:0] ActList     = 4'd7;
  localparam logic [ActW-1:0] ActListRev  = 4'd8;
  localparam logic [ActW-1:0] ActReverse  = 4'd9;

  localparam logic [StW-1:0] StOk       = 3'd0;
  localparam logic [StW-1:0] StBadPos   = 3'd1;
  localparam logic [StW-1:0] StOob      = 3'd2;
  localparam logic [StW-1:0] StEmpty    = 3'd3;
  localparam logic [StW-1:0] StNotFound = 3'd4;
  localparam logic [StW-1:0] StFull     = 3'd5;

  // datapath commands from the controller
  typedef struct packed {
    logic latch;     // capture request, set walk pointers
    logic step;      // advance walk one node
    logic push;      // record current node on stack (reverse listing)
    logic pop;       // pop stack
    logic rev_step;  // relink one node during reverse
    logic commit;    // apply insert or delete
    logic emit;      // load output register
    logic emit_stk;  // output value from stack top
    logic [StW-1:0] st;
    logic last;
    logic found;     // output position of walk
  } cmd_t;

  typedef struct packed {
    logic [ActW-1:0] act;
    logic at_nil;       // current walk node is null
    logic next_nil;     // successor of current walk node is null
    logic at_target;    // walk reached target position
    logic match;        // current node value equals key
    logic stk_one;
    logic free_empty;
    logic [7:0] pos;
    logic cnt_zero;
    logic pos_gt_cnt;   // pos > count
    logic pos_gt_cnt1;  // pos > count+1
    logic out_busy;
  } stat_t;
endpackage
`default_nettype wire

### rtl/core/blle_if.sv
// Valid/ready channel interface with generic payload.
// Depends on nothing.
`default_nettype none
interface blle_if #(parameter type payload_t = logic) ();
  logic valid;
  logic ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/core/bounded_linked_list_engine_top.sv
// Top level of the bounded linked list engine.
// Depends on blle_pkg, blle_if, blle_ctrl, blle_dp, blle_fwd.
//
//  channel | dir | fields
//  in_if   | in  | action, item_value, item_position
//  out_if  | out | status, out_value, out_position, last
//
// Begin operations finish in the check state; positional ones walk to
// their position, listing and reversal the whole list, one node a cycle
// through the link memory. Reset is asynchronous and leaves an empty list
// with every node free; no clearing pass. Output stalls hold the controller,
// relinking in reversal aside; input is accepted only between items.
`default_nettype none
module bounded_linked_list_engine_top #(
  parameter int unsigned Capacity = blle_pkg::CapacityDef
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  blle_if.sink in_if,
  blle_if.source out_if
);
  blle_pkg::cmd_t cmd;
  blle_pkg::stat_t stat;
  logic dv, dl, fr;
  logic [blle_pkg::StW-1:0] ds;
  logic [blle_pkg::ValW-1:0] dval;
  logic [blle_pkg::OPosW-1:0] dpos;

  blle_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(in_if.valid), .act_i(in_if.data.action),
    .in_ready_o(in_if.ready), .stat_i(stat), .cmd_o(cmd)
  );
  blle_dp #(.Capacity(Capacity)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat),
    .act_i(in_if.data.action), .val_i(in_if.data.item_value),
    .pos_i(in_if.data.item_position), .out_valid_o(dv), .out_ready_i(fr),
    .out_status_o(ds), .out_value_o(dval), .out_position_o(dpos), .out_last_o(dl)
  );
  blle_fwd u_fwd (
    .clk_i, .rst_ni, .in_valid_i(dv), .in_ready_o(fr), .in_status_i(ds),
    .in_value_i(dval), .in_position_i(dpos), .in_last_i(dl),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .out_status_o(out_if.data.status), .out_value_o(out_if.data.out_value),
    .out_position_o(out_if.data.out_position), .out_last_o(out_if.data.last)
  );
endmodule
`default_nettype wire

### rtl/core/blle_dp.sv
// Datapath: node pool memories, pointers, stack and output register.
// Depends on blle_pkg.
`default_nettype none
module blle_dp #(
  parameter int unsigned Capacity = blle_pkg::CapacityDef,
  localparam int unsigned IdxW = $clog2(Capacity + 1),
  localparam int unsigned CntW = $clog2(Capacity + 1)
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire blle_pkg::cmd_t cmd_i,
  output blle_pkg::stat_t stat_o,
  input  wire logic [blle_pkg::ActW-1:0] act_i,
  input  wire logic [blle_pkg::ValW-1:0] val_i,
  input  wire logic [blle_pkg::PosW-1:0] pos_i,
  output logic out_valid_o,
  input  wire logic out_ready_i,
  output logic [blle_pkg::StW-1:0] out_status_o,
  output logic [blle_pkg::ValW-1:0] out_value_o,
  output logic [blle_pkg::OPosW-1:0] out_position_o,
  output logic out_last_o
);
  localparam logic [IdxW-1:0] Nil = IdxW'(Capacity);
  localparam int unsigned AW = $clog2(Capacity);

  logic [blle_pkg::ValW-1:0] vals_q [Capacity];
  logic [IdxW-1:0] links_q [Capacity];
  logic [Capacity-1:0] links_v_q;
  logic [IdxW-1:0] stk_q [Capacity];
  logic [CntW-1:0] sp_q;

  logic [IdxW-1:0] head_q, free_q;
  logic [CntW-1:0] cnt_q;
  logic [blle_pkg::ActW-1:0] act_q;
  logic [blle_pkg::ValW-1:0] key_q;
  logic [blle_pkg::PosW-1:0] pos_q;
  logic [IdxW-1:0] cur_q, prev_q;
  logic [blle_pkg::PosW-1:0] idx_q;   // 1-based position of cur
  logic [blle_pkg::PosW-1:0] tgt;

  logic ov_q;

  function automatic logic [IdxW-1:0] lnk(
    input logic [IdxW-1:0] n, input logic [IdxW-1:0] l, input logic v);
    logic [IdxW-1:0] r;
    r = Nil;
    if (n < Nil) r = v ? l : IdxW'(32'(n) + 1);
    return r;
  endfunction

  logic cur_nil;
  logic [IdxW-1:0] cur_nx, prev_nx, free_nx;
  assign cur_nil = (cur_q >= Nil);
  assign cur_nx = cur_nil ? Nil : lnk(cur_q, links_q[cur_q[AW-1:0]], links_v_q[cur_q[AW-1:0]]);
  assign prev_nx = (prev_q >= Nil) ? Nil :
                   lnk(prev_q, links_q[prev_q[AW-1:0]], links_v_q[prev_q[AW-1:0]]);
  assign free_nx = (free_q >= Nil) ? Nil :
                   lnk(free_q, links_q[free_q[AW-1:0]], links_v_q[free_q[AW-1:0]]);

  // walk target: node at position tgt becomes cur, its predecessor prev
  always_comb begin
    tgt = '0;
    case (act_q)
      blle_pkg::ActInsEnd: tgt = blle_pkg::PosW'(cnt_q) + 8'd1;
      blle_pkg::ActDelEnd: tgt = blle_pkg::PosW'(cnt_q);
      default:             tgt = pos_q;
    endcase
  end

  always_comb begin
    stat_o = '0;
    stat_o.act = act_q;
    stat_o.at_nil = cur_nil;
    stat_o.next_nil = (cur_nx >= Nil);
    stat_o.at_target = (idx_q == tgt);
    stat_o.match = !cur_nil && (vals_q[cur_q[AW-1:0]] == key_q);
    stat_o.stk_one = (sp_q == CntW'(1));
    stat_o.free_empty = (free_q >= Nil);
    stat_o.pos = pos_q;
    stat_o.cnt_zero = (cnt_q == '0);
    stat_o.pos_gt_cnt = (9'(pos_q) > 9'(cnt_q));
    stat_o.pos_gt_cnt1 = (9'(pos_q) > 9'(cnt_q) + 9'd1);
    stat_o.out_busy = ov_q && !out_ready_i;
  end

  // insert links new node after prev (or at head); delete unlinks cur
  logic ins_op;
  assign ins_op = (act_q == blle_pkg::ActInsBegin) || (act_q == blle_pkg::ActInsEnd) ||
                  (act_q == blle_pkg::ActInsPos);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      links_v_q <= '0;
      head_q <= Nil;
      free_q <= '0;
      cnt_q <= '0;
      sp_q <= '0;
      cur_q <= Nil;
      prev_q <= Nil;
      idx_q <= '0;
      act_q <= '0;
    end else begin
      if (cmd_i.latch) begin
        act_q <= act_i;
        key_q <= val_i;
        pos_q <= pos_i;
        cur_q <= head_q;
        prev_q <= Nil;
        idx_q <= 8'd1;
        sp_q <= '0;
      end
      if (cmd_i.step) begin
        prev_q <= cur_q;
        cur_q <= cur_nx;
        idx_q <= idx_q + 8'd1;
      end
      if (cmd_i.push) begin
        stk_q[sp_q[AW-1:0]] <= cur_q;
        sp_q <= sp_q + CntW'(1);
      end
      if (cmd_i.pop) sp_q <= sp_q - CntW'(1);
      if (cmd_i.rev_step) begin
        links_q[cur_q[AW-1:0]] <= prev_q;
        links_v_q[cur_q[AW-1:0]] <= 1'b1;
        prev_q <= cur_q;
        cur_q <= cur_nx;
        head_q <= cur_q;
      end
      if (cmd_i.commit) begin
        if (ins_op) begin
          vals_q[free_q[AW-1:0]] <= key_q;
          links_q[free_q[AW-1:0]] <= cur_q;
          links_v_q[free_q[AW-1:0]] <= 1'b1;
          free_q <= free_nx;
          cnt_q <= cnt_q + CntW'(1);
          if (prev_q >= Nil) head_q <= free_q;
          else begin
            links_q[prev_q[AW-1:0]] <= free_q;
            links_v_q[prev_q[AW-1:0]] <= 1'b1;
          end
        end else begin
          if (prev_q >= Nil) head_q <= cur_nx;
          else begin
            links_q[prev_q[AW-1:0]] <= cur_nx;
            links_v_q[prev_q[AW-1:0]] <= 1'b1;
          end
          links_q[cur_q[AW-1:0]] <= free_q;
          links_v_q[cur_q[AW-1:0]] <= 1'b1;
          free_q <= cur_q;
          cnt_q <= cnt_q - CntW'(1);
        end
      end
    end
  end

  logic [IdxW-1:0] stop;
  assign stop = (sp_q == '0) ? Nil : stk_q[AW'(32'(sp_q) - 1)];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (cmd_i.emit) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_status_o <= cmd_i.st;
      out_last_o <= cmd_i.last;
      out_position_o <= cmd_i.found ? blle_pkg::OPosW'(idx_q) : '0;
      if (cmd_i.st != blle_pkg::StOk || cmd_i.found) out_value_o <= '0;
      else if (cmd_i.emit_stk) out_value_o <= vals_q[stop[AW-1:0]];
      else if (act_q == blle_pkg::ActList) out_value_o <= vals_q[cur_q[AW-1:0]];
      else out_value_o <= '0;
    end
  end
  assign out_valid_o = ov_q;
endmodule
`default_nettype wire

### rtl/core/blle_ctrl.sv
// Controller FSM for the linked list engine.
// Depends on blle_pkg.
`default_nettype none
module blle_ctrl (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  wire logic [blle_pkg::ActW-1:0] act_i,
  output logic in_ready_o,
  input  wire blle_pkg::stat_t stat_i,
  output blle_pkg::cmd_t cmd_o
);
  typedef enum logic [5:0] {
    SIdle  = 6'b000001,
    SCheck = 6'b000010,
    SWalk  = 6'b000100,
    SList  = 6'b001000,
    SPop   = 6'b010000,
    SRev   = 6'b100000
  } state_e;
  state_e state_q, state_d;

  logic busy;
  assign busy = stat_i.out_busy;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    case (state_q)
      SIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i && act_i <= blle_pkg::ActReverse) begin
          cmd_o.latch = 1'b1;
          state_d = SCheck;
        end
      end
      SCheck: if (!busy) begin
        cmd_o.last = 1'b1;
        state_d = SIdle;
        case (stat_i.act)
          blle_pkg::ActInsBegin: begin
            cmd_o.emit = 1'b1;
            if (stat_i.free_empty) cmd_o.st = blle_pkg::StFull;
            else cmd_o.commit = 1'b1;
          end
          blle_pkg::ActInsEnd, blle_pkg::ActInsPos: begin
            if (stat_i.act == blle_pkg::ActInsPos && stat_i.pos == '0) begin
              cmd_o.emit = 1'b1; cmd_o.st = blle_pkg::StBadPos;
            end else if (stat_i.act == blle_pkg::ActInsPos && stat_i.pos_gt_cnt1) begin
              cmd_o.emit = 1'b1; cmd_o.st = blle_pkg::StOob;
            end else if (stat_i.free_empty) begin
              cmd_o.emit = 1'b1; cmd_o.st = blle_pkg::StFull;
            end else begin
              cmd_o.last = 1'b0; state_d = SWalk;
            end
          end
          blle_pkg::ActDelBegin: begin
            cmd_o.emit = 1'b1;
            if (stat_i.at_nil) cmd_o.st = blle_pkg::StEmpty;
            else cmd_o.commit = 1'b1;
          end
          blle_pkg::ActDelEnd: begin
            if (stat_i.cnt_zero) begin
              cmd_o.emit = 1'b1; cmd_o.st = blle_pkg::StEmpty;
            end else begin
              cmd_o.last = 1'b0; state_d = SWalk;
            end
          end
          blle_pkg::ActDelPos: begin
            if (stat_i.pos == '0 || stat_i.cnt_zero) begin
              cmd_o.emit = 1'b1; cmd_o.st = blle_pkg::StBadPos;
            end else if (stat_i.pos_gt_cnt) begin
              cmd_o.emit = 1'b1; cmd_o.st = blle_pkg::StOob;
            end else begin
              cmd_o.last = 1'b0; state_d = SWalk;
            end
          end
          blle_pkg::ActSearch: begin
            cmd_o.last = 1'b0; state_d = SWalk;
          end
          blle_pkg::ActList, blle_pkg::ActListRev: begin
            if (stat_i.at_nil) begin
              cmd_o.emit = 1'b1; cmd_o.st = blle_pkg::StEmpty;
            end else begin
              cmd_o.last = 1'b0; state_d = SList;
            end
          end
          blle_pkg::ActReverse: begin
            cmd_o.last = 1'b0; state_d = SRev;
          end
          default: begin
            cmd_o.last = 1'b0;
          end
        endcase
      end
      SWalk: if (!busy) begin
        if (stat_i.act == blle_pkg::ActSearch) begin
          if (stat_i.at_nil) begin
            cmd_o.emit = 1'b1; cmd_o.last = 1'b1; cmd_o.st = blle_pkg::StNotFound;
            state_d = SIdle;
          end else if (stat_i.match) begin
            cmd_o.emit = 1'b1; cmd_o.last = 1'b1; cmd_o.found = 1'b1;
            state_d = SIdle;
          end else cmd_o.step = 1'b1;
        end else if (stat_i.at_target) begin
          cmd_o.commit = 1'b1; cmd_o.emit = 1'b1; cmd_o.last = 1'b1;
          state_d = SIdle;
        end else cmd_o.step = 1'b1;
      end
      SList: if (!busy) begin
        if (stat_i.act == blle_pkg::ActList) begin
          // forward listing: the tail is the node whose successor is null
          cmd_o.emit = 1'b1;
          cmd_o.step = 1'b1;
          cmd_o.last = stat_i.next_nil;
          if (stat_i.next_nil) state_d = SIdle;
        end else if (stat_i.at_nil) begin
          state_d = SPop;
        end else begin
          cmd_o.push = 1'b1; cmd_o.step = 1'b1;
        end
      end
      SPop: if (!busy) begin
        cmd_o.emit = 1'b1; cmd_o.emit_stk = 1'b1; cmd_o.pop = 1'b1;
        cmd_o.last = stat_i.stk_one;
        if (stat_i.stk_one) state_d = SIdle;
      end
      SRev: begin
        if (stat_i.at_nil) begin
          if (!busy) begin
            cmd_o.emit = 1'b1; cmd_o.last = 1'b1; cmd_o.st = blle_pkg::StOk;
            state_d = SIdle;
          end
        end else cmd_o.rev_step = 1'b1;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= SIdle;
    else state_q <= state_d;
  end
endmodule
`default_nettype wire

### rtl/core/blle_fwd.sv
// Output stage: one-entry result register between the datapath and the
// output channel. Depends on blle_pkg.
`default_nettype none
module blle_fwd (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic in_ready_o,
  input  wire logic [blle_pkg::StW-1:0] in_status_i,
  input  wire logic [blle_pkg::ValW-1:0] in_value_i,
  input  wire logic [blle_pkg::OPosW-1:0] in_position_i,
  input  wire logic in_last_i,
  output logic out_valid_o,
  input  wire logic out_ready_i,
  output logic [blle_pkg::StW-1:0] out_status_o,
  output logic [blle_pkg::ValW-1:0] out_value_o,
  output logic [blle_pkg::OPosW-1:0] out_position_o,
  output logic out_last_o
);
  logic hv_q;
  logic [blle_pkg::StW-1:0] hs_q;
  logic [blle_pkg::ValW-1:0] hval_q;
  logic [blle_pkg::OPosW-1:0] hp_q;
  logic hl_q;
  assign out_valid_o = hv_q;
  assign out_status_o = hs_q;
  assign out_value_o = hval_q;
  assign out_position_o = hp_q;
  assign out_last_o = hl_q;
  assign in_ready_o = !hv_q || out_ready_i;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) hv_q <= 1'b0;
    else if (in_ready_o) hv_q <= in_valid_i;
  end
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      hs_q <= in_status_i; hval_q <= in_value_i; hp_q <= in_position_i; hl_q <= in_last_i;
    end
  end
endmodule
`default_nettype wire

### rtl/core/blle_checker.sv
// Port-level checker for the linked list engine, bound to the top level.
// Depends on blle_pkg and the macro header.
`default_nettype none
`include "bounded_linked_list_engine_top_macros.svh"
module blle_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_i,
  input wire logic [blle_pkg::ActW-1:0] action_i,
  input wire logic out_valid_i,
  input wire logic out_ready_i,
  input wire logic [blle_pkg::StW-1:0] status_i,
  input wire logic [blle_pkg::OPosW-1:0] out_position_i
);
  `BLL_ASSERT_IMP(a_status_range, clk_i, rst_ni, out_valid_i, status_i <= blle_pkg::StFull)
  `BLL_ASSERT_IMP(a_pos_range, clk_i, rst_ni, out_valid_i, out_position_i <= 7'd64)
  // a real request leaves the engine not ready in the cycle after it is taken
  `BLL_ASSERT_NXT(a_busy_after_req, clk_i, rst_ni, in_valid_i && in_ready_i && (action_i <= blle_pkg::ActReverse), !in_ready_i)
  `BLL_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(status_i) && $stable(out_position_i))
endmodule
bind bounded_linked_list_engine_top blle_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i(in_if.valid), .in_ready_i(in_if.ready),
  .action_i(in_if.data.action),
  .out_valid_i(out_if.valid), .out_ready_i(out_if.ready),
  .status_i(out_if.data.status), .out_position_i(out_if.data.out_position)
);
`default_nettype wire
